[hdl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CHK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pair list check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pair list check failed");

`endif

[hdl/plist_pkg.sv]
// Types and codes shared by the pair list modules.
package plist_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // Per-cell load select: new pair, lower neighbour or upper neighbour.
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_sel_t;

endpackage

[hdl/plist_cell.sv]
// One list slot: holds a pair and loads it from the input or a neighbour.
module plist_cell import plist_pkg::*; #(
  parameter int FIRST_BITS  = 32,
  parameter int SECOND_BITS = 32
) (
  input  logic                   clk,
  input  cell_sel_t              sel,
  input  logic [FIRST_BITS-1:0]  new_first,
  input  logic [SECOND_BITS-1:0] new_second,
  input  logic [FIRST_BITS-1:0]  left_first,
  input  logic [SECOND_BITS-1:0] left_second,
  input  logic [FIRST_BITS-1:0]  right_first,
  input  logic [SECOND_BITS-1:0] right_second,
  output logic [FIRST_BITS-1:0]  first,
  output logic [SECOND_BITS-1:0] second
);

  always_ff @(posedge clk) begin
    priority if (sel.load_new) begin
      first  <= new_first;
      second <= new_second;
    end else if (sel.take_left) begin
      first  <= left_first;
      second <= left_second;
    end else if (sel.take_right) begin
      first  <= right_first;
      second <= right_second;
    end else begin
      first  <= first;
      second <= second;
    end
  end

endmodule

[hdl/pair_list_insert_remove_range_top.sv]
// Fixed-capacity pair list: slot chain with append, insert, read, range removal.
// Request channel (req_valid / req_stall) carries func, position, count and a pair.
// Response channel (rsp_valid / rsp_stall) carries status, has_element, the pair,
// fill_level and last; every request gives at least one response, the final
// one with last set.
// Append, insert, read, failed requests and an empty remove answer in the cycle
// after acceptance; with the response taken at once a new request is accepted
// every cycle.
// A remove of n entries is accepted and range-checked, then takes out one pair
// per step, shifting every slot above the removal point down by one through the
// slot chain; steps wait on a stalled response and the request side is stalled.
// Fill_level on every response is the level after the whole request.
// Reset clears the entry count, the state and rsp_valid; slot contents are not
// cleared, as only slots below the fill level are read.
// While a waiting response is stalled it holds and no request is accepted.
module pair_list_insert_remove_range_top import plist_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int FIRST_BITS  = 32,
  parameter int SECOND_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   func,
  input  logic [$clog2(DEPTH+1)-1:0]   position,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [FIRST_BITS-1:0]        first_value,
  input  logic [SECOND_BITS-1:0]       second_value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic                         has_element,
  output logic [FIRST_BITS-1:0]        out_first,
  output logic [SECOND_BITS-1:0]       out_second,
  output logic [$clog2(DEPTH+1)-1:0]   fill_level,
  output logic                         last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REMOVE = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [CNT_W-1:0]   rm_pos, rm_left, rm_fill;
  logic               rm_start;

  logic               accept, slot_free, load_rsp;
  logic               ins_en, del_en;
  logic [CNT_W-1:0]   op_pos;
  logic [CNT_W:0]     rm_end;

  logic [1:0]             status_next;
  logic                   has_next, last_next;
  logic [FIRST_BITS-1:0]  first_next;
  logic [SECOND_BITS-1:0] second_next;
  logic [CNT_W-1:0]       fill_next;

  logic [FIRST_BITS-1:0]  cell_first  [DEPTH];
  logic [SECOND_BITS-1:0] cell_second [DEPTH];
  logic [FIRST_BITS-1:0]  rd_first;
  logic [SECOND_BITS-1:0] rd_second;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == ST_IDLE) && slot_free);
  assign accept    = req_valid && !req_stall;
  assign rm_end    = {1'b0, position} + {1'b0, count};

  // Single read port on the slot chain.
  assign rd_first  = cell_first[op_pos[IDX_W-1:0]];
  assign rd_second = cell_second[op_pos[IDX_W-1:0]];

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    load_rsp         = 1'b0;
    rm_start         = 1'b0;
    ins_en           = 1'b0;
    del_en           = 1'b0;
    op_pos           = position;
    status_next      = STATUS_OK;
    has_next         = 1'b0;
    last_next        = 1'b1;
    first_next       = '0;
    second_next      = '0;
    fill_next        = entry_count;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          load_rsp = 1'b1;
          unique case (func_t'(func))
            FUNC_APPEND: begin
              if (entry_count >= CNT_W'(DEPTH)) begin
                status_next = STATUS_FULL;
              end else begin
                ins_en           = 1'b1;
                op_pos           = entry_count;
                entry_count_next = entry_count + 1'b1;
                fill_next        = entry_count_next;
              end
            end
            FUNC_INSERT: begin
              priority if (entry_count >= CNT_W'(DEPTH)) begin
                status_next = STATUS_FULL;
              end else if (position > entry_count) begin
                status_next = STATUS_RANGE;
              end else begin
                ins_en           = 1'b1;
                entry_count_next = entry_count + 1'b1;
                fill_next        = entry_count_next;
              end
            end
            FUNC_REMOVE: begin
              priority if (rm_end > {1'b0, entry_count}) begin
                status_next = STATUS_RANGE;
              end else if (count == '0) begin
                status_next = STATUS_OK;
              end else begin
                // Pairs leave one per cycle from the removal point unless stalled.
                load_rsp         = 1'b0;
                rm_start         = 1'b1;
                entry_count_next = entry_count - count;
                state_next       = ST_REMOVE;
              end
            end
            FUNC_READ: begin
              if (position >= entry_count) begin
                status_next = STATUS_RANGE;
              end else begin
                has_next    = 1'b1;
                first_next  = rd_first;
                second_next = rd_second;
              end
            end
            default: status_next = STATUS_RANGE;
          endcase
        end
      end
      ST_REMOVE: begin
        op_pos = rm_pos;
        if (slot_free) begin
          load_rsp    = 1'b1;
          del_en      = 1'b1;
          has_next    = 1'b1;
          first_next  = rd_first;
          second_next = rd_second;
          fill_next   = rm_fill;
          last_next   = (rm_left == CNT_W'(1));
          if (last_next) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      rm_left     <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (rm_start) begin
        rm_left <= count;
      end else if (del_en) begin
        rm_left <= rm_left - 1'b1;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rm_start) begin
      rm_pos  <= position;
      rm_fill <= entry_count_next;
    end
    if (load_rsp) begin
      status      <= status_next;
      has_element <= has_next;
      out_first   <= first_next;
      out_second  <= second_next;
      fill_level  <= fill_next;
      last        <= last_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    cell_sel_t              sel;
    logic [FIRST_BITS-1:0]  left_first, right_first;
    logic [SECOND_BITS-1:0] left_second, right_second;

    assign sel.load_new   = ins_en && (IDX == op_pos);
    assign sel.take_left  = ins_en && (IDX > op_pos);
    assign sel.take_right = del_en && (IDX >= op_pos);

    if (i == 0) begin : g_bottom
      assign left_first  = cell_first[i];
      assign left_second = cell_second[i];
    end else begin : g_lower
      assign left_first  = cell_first[i-1];
      assign left_second = cell_second[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign right_first  = cell_first[i];
      assign right_second = cell_second[i];
    end else begin : g_upper
      assign right_first  = cell_first[i+1];
      assign right_second = cell_second[i+1];
    end

    plist_cell #(
      .FIRST_BITS  (FIRST_BITS),
      .SECOND_BITS (SECOND_BITS)
    ) u_cell (
      .clk          (clk),
      .sel          (sel),
      .new_first    (first_value),
      .new_second   (second_value),
      .left_first   (left_first),
      .left_second  (left_second),
      .right_first  (right_first),
      .right_second (right_second),
      .first        (cell_first[i]),
      .second       (cell_second[i])
    );
  end

endmodule

[hdl/plist_checker.sv]
// Port-level checks on the pair list and their binding to the top level.
`include "assert_macros.svh"

module plist_checker import plist_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int FIRST_BITS  = 32,
  parameter int SECOND_BITS = 32
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_stall,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic [1:0]                 status,
  input logic                       has_element,
  input logic [FIRST_BITS-1:0]      out_first,
  input logic [SECOND_BITS-1:0]     out_second,
  input logic [$clog2(DEPTH+1)-1:0] fill_level,
  input logic                       last
);

  localparam int RSP_W = 4 + FIRST_BITS + SECOND_BITS + $clog2(DEPTH + 1);

  logic [RSP_W-1:0] rsp_word;

  assign rsp_word = {status, has_element, out_first, out_second, fill_level, last};

  // Only a range removal yields more than one transaction, each carrying a pair.
  `CHK_IMPL(a_mid_is_removal, rsp_valid && !last, has_element && (status == STATUS_OK))

  // A failed request never carries a pair.
  `CHK_IMPL(a_fail_no_pair, rsp_valid && (status != STATUS_OK), !has_element)

  // Hold off requests until a removal has emitted its final pair.
  `CHK_IMPL(a_removal_blocks, rsp_valid && !last, req_stall)

  `CHK_IMPL(a_fill_bound, rsp_valid, fill_level <= DEPTH)

  `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind pair_list_insert_remove_range_top plist_checker #(
  .DEPTH       (DEPTH),
  .FIRST_BITS  (FIRST_BITS),
  .SECOND_BITS (SECOND_BITS)
) u_plist_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the pair list block: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
  import plist_pkg::*;

  localparam int DEPTH       = 16;
  localparam int FIRST_BITS  = 32;
  localparam int SECOND_BITS = 32;
  localparam int PW          = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS  = 240;
  localparam int QUIET_ITEMS = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DIR_ROWS    = 26;

  typedef struct packed {
    logic [1:0]             status;
    logic                   has;
    logic [FIRST_BITS-1:0]  first;
    logic [SECOND_BITS-1:0] second;
    logic [PW-1:0]          fill;
    logic                   last;
  } rsp_t;

  typedef struct packed {
    func_t                  op;
    logic [PW-1:0]          pos;
    logic [PW-1:0]          cnt;
    logic [FIRST_BITS-1:0]  a;
    logic [SECOND_BITS-1:0] b;
    logic [4:0]             reps;
    logic                   typed;
    status_t                st;
    logic [PW-1:0]          fill;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  logic [1:0]             func;
  logic [PW-1:0]          position;
  logic [PW-1:0]          count;
  logic [FIRST_BITS-1:0]  first_value;
  logic [SECOND_BITS-1:0] second_value;
  logic                   rsp_valid;
  logic                   rsp_stall;
  logic [1:0]             status;
  logic                   has_element;
  logic [FIRST_BITS-1:0]  out_first;
  logic [SECOND_BITS-1:0] out_second;
  logic [PW-1:0]          fill_level;
  logic                   last;

  // Shadow copy of the list contents
  logic [FIRST_BITS-1:0]  pair_first [DEPTH];
  logic [SECOND_BITS-1:0] pair_second [DEPTH];
  int                     fill_cnt;

  rsp_t rsp_expected [$];
  rsp_t rsp_fresh [$];
  int   err_cnt;
  int   idle_cycles;
  bit   quiet;
  bit   calm;
  bit   hold_pending;

  // Directed rows: expected status and fill typed in where obvious
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{FUNC_READ,    5'd0,  5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_RANGE, 5'd0},
    '{FUNC_REMOVE,  5'd0,  5'd1,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_RANGE, 5'd0},
    '{FUNC_REMOVE,  5'd0,  5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_OK,    5'd0},
    '{FUNC_INSERT,  5'd1,  5'd0,  32'hdeadbeef, 32'hcafef00d, 5'd1,  1'b1, STATUS_RANGE, 5'd0},
    '{FUNC_APPEND,  5'd0,  5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_OK,    5'd1},
    '{FUNC_APPEND,  5'd0,  5'd0,  32'hffffffff, 32'hffffffff, 5'd1,  1'b1, STATUS_OK,    5'd2},
    '{FUNC_INSERT,  5'd0,  5'd0,  32'ha5a5a5a5, 32'h5a5a5a5a, 5'd1,  1'b1, STATUS_OK,    5'd3},
    '{FUNC_INSERT,  5'd3,  5'd0,  32'h12345678, 32'h87654321, 5'd1,  1'b1, STATUS_OK,    5'd4},
    '{FUNC_INSERT,  5'd2,  5'd0,  32'h0000ffff, 32'hffff0000, 5'd1,  1'b1, STATUS_OK,    5'd5},
    '{FUNC_READ,    5'd0,  5'd0,  32'h0,        32'h0,        5'd1,  1'b0, STATUS_OK,    5'd0},
    '{FUNC_READ,    5'd5,  5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_RANGE, 5'd5},
    '{FUNC_REMOVE,  5'd1,  5'd2,  32'h0,        32'h0,        5'd1,  1'b0, STATUS_OK,    5'd0},
    '{FUNC_REMOVE,  5'd2,  5'd1,  32'h0,        32'h0,        5'd1,  1'b0, STATUS_OK,    5'd0},
    '{FUNC_APPEND,  5'd0,  5'd0,  32'h00000100, 32'h80000000, 5'd14, 1'b0, STATUS_OK,    5'd0},
    '{FUNC_APPEND,  5'd0,  5'd0,  32'h11111111, 32'h22222222, 5'd1,  1'b1, STATUS_FULL,  5'd16},
    '{FUNC_INSERT,  5'd0,  5'd0,  32'h33333333, 32'h44444444, 5'd1,  1'b1, STATUS_FULL,  5'd16},
    '{FUNC_INSERT,  5'd16, 5'd0,  32'h55555555, 32'h66666666, 5'd1,  1'b1, STATUS_FULL,  5'd16},
    '{FUNC_READ,    5'd15, 5'd0,  32'h0,        32'h0,        5'd1,  1'b0, STATUS_OK,    5'd0},
    '{FUNC_READ,    5'd16, 5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_RANGE, 5'd16},
    '{FUNC_REMOVE,  5'd16, 5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_OK,    5'd16},
    '{FUNC_REMOVE,  5'd0,  5'd16, 32'h0,        32'h0,        5'd1,  1'b0, STATUS_OK,    5'd0},
    '{FUNC_APPEND,  5'd0,  5'd0,  32'h80000000, 32'h00000001, 5'd1,  1'b1, STATUS_OK,    5'd1},
    '{FUNC_REMOVE,  5'd1,  5'd0,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_OK,    5'd1},
    '{FUNC_REMOVE,  5'd0,  5'd2,  32'h0,        32'h0,        5'd1,  1'b1, STATUS_RANGE, 5'd1},
    '{FUNC_REMOVE,  5'd16, 5'd16, 32'h0,        32'h0,        5'd1,  1'b1, STATUS_RANGE, 5'd1},
    '{FUNC_READ,    5'd0,  5'd0,  32'h0,        32'h0,        5'd1,  1'b0, STATUS_OK,    5'd0}
  };

  pair_list_insert_remove_range_top #(
    .DEPTH       (DEPTH),
    .FIRST_BITS  (FIRST_BITS),
    .SECOND_BITS (SECOND_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .position     (position),
    .count        (count),
    .first_value  (first_value),
    .second_value (second_value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .has_element  (has_element),
    .out_first    (out_first),
    .out_second   (out_second),
    .fill_level   (fill_level),
    .last         (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void note_rsp(status_t st, logic has, logic [FIRST_BITS-1:0] f,
                                   logic [SECOND_BITS-1:0] s, logic fin);
    rsp_t r;
    r.status = st;
    r.has    = has;
    r.first  = has ? f : '0;
    r.second = has ? s : '0;
    r.fill   = PW'(fill_cnt);
    r.last   = fin;
    rsp_fresh = {rsp_fresh, r};
  endfunction

  // Apply one operation to the shadow list and collect the responses it gives
  function automatic void list_step(func_t op, int pos, int cnt,
                                    logic [FIRST_BITS-1:0] a, logic [SECOND_BITS-1:0] b);
    logic [FIRST_BITS-1:0]  gone_first [DEPTH];
    logic [SECOND_BITS-1:0] gone_second [DEPTH];
    rsp_fresh.delete();
    case (op)
      FUNC_APPEND, FUNC_INSERT: begin
        if (fill_cnt >= DEPTH) begin
          note_rsp(STATUS_FULL, 1'b0, '0, '0, 1'b1);
        end else if (op == FUNC_INSERT && pos > fill_cnt) begin
          note_rsp(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
        end else begin
          if (op == FUNC_APPEND) pos = fill_cnt;
          for (int i = fill_cnt; i > pos; i--) begin
            pair_first[i]  = pair_first[i-1];
            pair_second[i] = pair_second[i-1];
          end
          pair_first[pos]  = a;
          pair_second[pos] = b;
          fill_cnt++;
          note_rsp(STATUS_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      FUNC_REMOVE: begin
        if (pos + cnt > fill_cnt) begin
          note_rsp(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
        end else if (cnt == 0) begin
          note_rsp(STATUS_OK, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < cnt; i++) begin
            gone_first[i]  = pair_first[pos+i];
            gone_second[i] = pair_second[pos+i];
          end
          // close the gap
          for (int i = pos + cnt; i < fill_cnt; i++) begin
            pair_first[i-cnt]  = pair_first[i];
            pair_second[i-cnt] = pair_second[i];
          end
          fill_cnt -= cnt;
          for (int i = 0; i < cnt; i++)
            note_rsp(STATUS_OK, 1'b1, gone_first[i], gone_second[i], i == cnt - 1);
        end
      end
      default: begin
        if (pos >= fill_cnt) note_rsp(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
        else note_rsp(STATUS_OK, 1'b1, pair_first[pos], pair_second[pos], 1'b1);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom();
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic offer(func_t op, int pos, int cnt,
                       logic [FIRST_BITS-1:0] a, logic [SECOND_BITS-1:0] b);
    bit taken;
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid    <= 1'b1;
    func         <= op;
    position     <= PW'(pos);
    count        <= PW'(cnt);
    first_value  <= a;
    second_value <= b;
    // Sample the stall mid-cycle, where it holds the value seen at the next edge
    do begin
      @(negedge clk);
      taken = (req_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic push_fresh();
    foreach (rsp_fresh[i]) rsp_expected = {rsp_expected, rsp_fresh[i]};
  endtask

  // Stimulus
  initial begin
    dir_row_t row;
    rsp_t     typed_rsp;
    func_t    op;
    int       pos;
    int       cnt;
    int       room;
    int       sel;
    int       grow;
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    func         <= FUNC_APPEND;
    position     <= '0;
    count        <= '0;
    first_value  <= '0;
    second_value <= '0;
    fill_cnt     = 0;
    err_cnt      = 0;
    quiet        = 1'b0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      for (int k = 0; k < row.reps; k++) begin
        offer(row.op, row.pos, row.cnt, row.a + k, row.b ^ k);
        list_step(row.op, row.pos, row.cnt, row.a + k, row.b ^ k);
        if (row.typed) begin
          typed_rsp = '{status: row.st, has: 1'b0, first: '0, second: '0,
                        fill: row.fill, last: 1'b1};
          rsp_expected = {rsp_expected, typed_rsp};
        end else begin
          push_fresh();
        end
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 20) hold_pending = 1'b1;
      quiet = (n >= RAND_ITEMS - QUIET_ITEMS);
      if ($urandom_range(0, 99) < 8) begin
        // noise: any function, with position and count anywhere from 0 to DEPTH
        op  = func_t'($urandom_range(0, 3));
        pos = $urandom_range(0, DEPTH);
        cnt = $urandom_range(0, DEPTH);
      end else begin
        grow = (fill_cnt == DEPTH) ? 10 : (fill_cnt < 6 ? 70 : 45);
        sel  = $urandom_range(0, 99);
        cnt  = 0;
        if (sel < grow) begin
          op  = ($urandom_range(0, 1) == 0) ? FUNC_APPEND : FUNC_INSERT;
          pos = $urandom_range(0, fill_cnt);
        end else if (sel < grow + 30) begin
          op   = FUNC_REMOVE;
          pos  = $urandom_range(0, fill_cnt);
          room = fill_cnt - pos;
          if (room > 4 && $urandom_range(0, 9) != 0) room = 4;
          cnt  = $urandom_range(0, room);
        end else begin
          op  = FUNC_READ;
          pos = (fill_cnt == 0) ? 0 : $urandom_range(0, fill_cnt - 1);
        end
      end
      offer(op, pos, cnt, pick_word(), pick_word());
      list_step(op, pos, cnt, first_value, second_value);
      push_fresh();
    end
    req_valid <= 1'b0;

    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Response side back-pressure, with one long hold-off early in the random phase
  initial begin
    int stall_len;
    int run_len;
    rsp_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet && hold_pending) begin
        hold_pending = 1'b0;
        stall_len    = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 1) == 0) begin
        stall_len = $urandom_range(1, 12);
      end else begin
        stall_len = 0;
      end
      if (stall_len != 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got);
    if (got !== want_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got);
      err_cnt++;
    end
  endfunction

  // Compare every accepted response with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (rsp_expected.size() == 0) begin
        $error("response with nothing expected: status %0d fill %0d", status, fill_level);
        err_cnt++;
      end else begin
        want = rsp_expected.pop_front();
        check_field("status", want.status, status);
        check_field("has_element", want.has, has_element);
        check_field("out_first", want.first, out_first);
        check_field("out_second", want.second, out_second);
        check_field("fill_level", want.fill, fill_level);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid === 1'b1 && req_stall === 1'b0) ||
        (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
